[rtl/arcade_drive_mixer_top_defines.svh]
// Assertion macros shared by the drive mixer RTL.
`ifndef ARCADE_DRIVE_MIXER_TOP_DEFINES_SVH
`define ARCADE_DRIVE_MIXER_TOP_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define ADM_ASSERT_IMPL(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define ADM_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

[rtl/adm_pkg.sv]
// Package of types and constants for the arcade drive mixer.
`default_nettype none
package adm_pkg;

  localparam int ADM_CHANNELS = 8;
  localparam int ADM_DRIVE_W  = 16;
  localparam int ADM_MIX_W    = 18;
  localparam int ADM_CFG_W    = 8;

  typedef logic signed [ADM_DRIVE_W-1:0] drive_t;
  typedef logic signed [ADM_MIX_W-1:0]   mix_t;
  typedef logic [ADM_CHANNELS-1:0]       chan_mask_t;

  localparam drive_t ADM_UNITY     = 16'sd16384;
  localparam drive_t ADM_NEG_UNITY = -16'sd16384;
  localparam mix_t   ADM_MIX_UNITY = 18'sd16384;
  localparam mix_t   ADM_MIX_NEG_UNITY = -18'sd16384;

  // Command codes
  localparam logic [1:0] ACT_ARCADE = 2'd0;
  localparam logic [1:0] ACT_RIGHT  = 2'd1;
  localparam logic [1:0] ACT_LEFT   = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_PRESENT    = 2'd0;
  localparam logic [1:0] REG_REVERSE    = 2'd1;
  localparam logic [1:0] REG_RIGHT_SIDE = 2'd2;

  localparam chan_mask_t RIGHT_SIDE_RESET = 8'hF0;

  // Saturate a raw command to plus or minus unity
  function automatic drive_t clamp_unit(input drive_t x);
    drive_t res;
    if (x > ADM_UNITY) res = ADM_UNITY;
    else if (x < ADM_NEG_UNITY) res = ADM_NEG_UNITY;
    else res = x;
    return res;
  endfunction

endpackage
`default_nettype wire

[rtl/arcade_drive_mixer_top.sv]
// Top level of the arcade drive mixer: five-stage pipeline and config registers.
`default_nettype none
`include "arcade_drive_mixer_top_defines.svh"
// Takes one command per clock and gives the eight drive values and the write
// mask after every stage, for one cycle, marked by out_strobe.
// The pipeline never stalls, so busy stays low and a command may be given on
// every clock; the stages are clamp, side mix, positive desaturation, negative
// desaturation and per-channel routing with sign reversal. Configuration
// registers are read at the routing stage and should only be written while no
// command is in flight. A result must be taken in its strobe cycle.
module arcade_drive_mixer_top
  import adm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           in_action,
  input  wire logic signed [15:0]   in_speed,
  input  wire logic signed [15:0]   in_turn,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [ADM_CFG_W-1:0] cfg_wdata,
  output logic                      out_strobe,
  output logic signed [15:0]        out_drive_0,
  output logic signed [15:0]        out_drive_1,
  output logic signed [15:0]        out_drive_2,
  output logic signed [15:0]        out_drive_3,
  output logic signed [15:0]        out_drive_4,
  output logic signed [15:0]        out_drive_5,
  output logic signed [15:0]        out_drive_6,
  output logic signed [15:0]        out_drive_7,
  output logic [7:0]                out_write_mask
);

  logic in_fire;

  chan_mask_t present_r, reverse_r, right_r;

  logic       s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, out_strobe_r;
  logic [1:0] s1_act_r, s2_act_r, s3_act_r, s4_act_r;
  drive_t     s1_speed_r, s1_half_r;
  mix_t       s2_rv_r, s2_lv_r;
  mix_t       s3_rv_r, s3_lv_r, s3_rv_nxt, s3_lv_nxt;
  mix_t       s4_rv_r, s4_lv_r, s4_rv_nxt, s4_lv_nxt;

  drive_t     drive_r [ADM_CHANNELS];
  drive_t     drive_nxt [ADM_CHANNELS];
  chan_mask_t wmask_r, wmask_nxt;

  assign busy    = 1'b0;
  assign in_fire = start && !busy;

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
      reverse_r <= '0;
      right_r   <= RIGHT_SIDE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PRESENT:    present_r <= cfg_wdata;
        REG_REVERSE:    reverse_r <= cfg_wdata;
        REG_RIGHT_SIDE: right_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r     <= 1'b0;
      s2_vld_r     <= 1'b0;
      s3_vld_r     <= 1'b0;
      s4_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      s1_vld_r     <= in_fire;
      s2_vld_r     <= s1_vld_r;
      s3_vld_r     <= s2_vld_r;
      s4_vld_r     <= s3_vld_r;
      out_strobe_r <= s4_vld_r;
    end
  end

  // Stage 1: clamp both commands and halve the turn (floor)
  always_ff @(posedge clk) begin
    drive_t turn_c;
    turn_c     = clamp_unit(in_turn);
    s1_act_r   <= in_action;
    s1_speed_r <= clamp_unit(in_speed);
    s1_half_r  <= turn_c >>> 1;
  end

  // Stage 2: mix the two sides; a side-only command carries its clamped speed
  // on both sides, which the desaturation stages leave untouched
  always_ff @(posedge clk) begin
    s2_act_r <= s1_act_r;
    if (s1_act_r == ACT_ARCADE) begin
      s2_rv_r <= mix_t'(s1_speed_r) - mix_t'(s1_half_r);
      s2_lv_r <= mix_t'(s1_speed_r) + mix_t'(s1_half_r);
    end else begin
      s2_rv_r <= mix_t'(s1_speed_r);
      s2_lv_r <= mix_t'(s1_speed_r);
    end
  end

  // Stage 3: move any overflow above unity onto the other side
  always_comb begin
    s3_rv_nxt = s2_rv_r;
    s3_lv_nxt = s2_lv_r;
    if (s2_lv_r > ADM_MIX_UNITY) begin
      s3_rv_nxt = s2_rv_r - s2_lv_r + ADM_MIX_UNITY;
      s3_lv_nxt = ADM_MIX_UNITY;
    end else if (s2_rv_r > ADM_MIX_UNITY) begin
      s3_lv_nxt = s2_lv_r - s2_rv_r + ADM_MIX_UNITY;
      s3_rv_nxt = ADM_MIX_UNITY;
    end
  end

  always_ff @(posedge clk) begin
    s3_act_r <= s2_act_r;
    s3_rv_r  <= s3_rv_nxt;
    s3_lv_r  <= s3_lv_nxt;
  end

  // Stage 4: move any overflow below minus unity onto the other side
  always_comb begin
    s4_rv_nxt = s3_rv_r;
    s4_lv_nxt = s3_lv_r;
    if (s3_lv_r < ADM_MIX_NEG_UNITY) begin
      s4_rv_nxt = s3_rv_r - s3_lv_r + ADM_MIX_NEG_UNITY;
      s4_lv_nxt = ADM_MIX_NEG_UNITY;
    end else if (s3_rv_r < ADM_MIX_NEG_UNITY) begin
      s4_lv_nxt = s3_lv_r - s3_rv_r + ADM_MIX_NEG_UNITY;
      s4_rv_nxt = ADM_MIX_NEG_UNITY;
    end
  end

  always_ff @(posedge clk) begin
    s4_act_r <= s3_act_r;
    s4_rv_r  <= s4_rv_nxt;
    s4_lv_r  <= s4_lv_nxt;
  end

  // Stage 5: pick the side values for the command and route them per channel
  always_comb begin
    drive_t rv, lv, v;
    rv        = drive_t'(s4_rv_r[ADM_DRIVE_W-1:0]);
    lv        = drive_t'(s4_lv_r[ADM_DRIVE_W-1:0]);
    wmask_nxt = '0;
    case (s4_act_r)
      ACT_ARCADE: begin
        wmask_nxt = present_r;
      end
      ACT_RIGHT: begin
        lv        = '0;
        wmask_nxt = present_r & right_r;
      end
      ACT_LEFT: begin
        rv        = '0;
        wmask_nxt = present_r & ~right_r;
      end
      default: begin
        wmask_nxt = '0;
      end
    endcase
    for (int k = 0; k < ADM_CHANNELS; k++) begin
      v = right_r[k] ? rv : lv;
      if (reverse_r[k]) v = -v;
      drive_nxt[k] = wmask_nxt[k] ? v : '0;
    end
  end

  always_ff @(posedge clk) begin
    wmask_r <= wmask_nxt;
    for (int k = 0; k < ADM_CHANNELS; k++) begin
      drive_r[k] <= drive_nxt[k];
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_write_mask = wmask_r;
  assign out_drive_0    = drive_r[0];
  assign out_drive_1    = drive_r[1];
  assign out_drive_2    = drive_r[2];
  assign out_drive_3    = drive_r[3];
  assign out_drive_4    = drive_r[4];
  assign out_drive_5    = drive_r[5];
  assign out_drive_6    = drive_r[6];
  assign out_drive_7    = drive_r[7];

  // Checks on the pipeline
  `ADM_ASSERT_NEXT(a_enter_stage1, in_fire, s1_vld_r, "transfer did not enter the pipeline")
  `ADM_ASSERT_IMPL(a_desat_range,
    s4_vld_r && s4_act_r == ACT_ARCADE,
    s4_rv_r <= ADM_MIX_UNITY && s4_rv_r >= ADM_MIX_NEG_UNITY &&
    s4_lv_r <= ADM_MIX_UNITY && s4_lv_r >= ADM_MIX_NEG_UNITY,
    "desaturated side value out of range")
  `ADM_ASSERT_NEXT(a_unused_code,
    s4_vld_r && s4_act_r == ACT_NONE,
    out_strobe_r && wmask_r == '0,
    "unused command code wrote a channel")

  for (genvar g = 0; g < ADM_CHANNELS; g++) begin : g_chk
    `ADM_ASSERT_IMPL(a_unwritten_zero, out_strobe_r && !wmask_r[g], drive_r[g] == '0,
      "unwritten channel carries a non-zero drive")
  end

endmodule
`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the arcade drive mixer: directed and random commands.
`timescale 1ns / 1ps

module testbench;
  import adm_pkg::*;

  localparam int UNITY_Q14 = 16384;

  typedef struct packed {
    logic [ADM_CHANNELS-1:0][15:0] drive;
    chan_mask_t                    write_mask;
  } drive_result_t;

  // Scoreboard: predicts the drive set for each command and checks the results in order
  class drive_mix_scoreboard;
    chan_mask_t    present_mask;
    chan_mask_t    reverse_mask;
    chan_mask_t    right_mask;
    int            failures;
    drive_result_t expected_drive_q[$];

    function new();
      present_mask = '0;
      reverse_mask = '0;
      right_mask   = RIGHT_SIDE_RESET;
      failures     = 0;
    endfunction

    function int pending();
      return expected_drive_q.size();
    endfunction

    function int saturate_q14(logic signed [15:0] raw);
      int v;
      v = raw;
      if (v > UNITY_Q14) v = UNITY_Q14;
      else if (v < -UNITY_Q14) v = -UNITY_Q14;
      return v;
    endfunction

    // Work out the drive set for one accepted command
    function void note_command(logic [1:0] action, logic signed [15:0] speed,
                               logic signed [15:0] turn);
      int            s;
      int            t;
      int            half_turn;
      int            right_v;
      int            left_v;
      int            v;
      chan_mask_t    mask;
      drive_result_t exp_r;
      s       = saturate_q14(speed);
      t       = saturate_q14(turn);
      right_v = 0;
      left_v  = 0;
      mask    = '0;
      case (action)
        ACT_ARCADE: begin
          half_turn = t >>> 1;
          right_v   = s - half_turn;
          left_v    = s + half_turn;
          // shift any positive overflow onto the other side
          if (left_v > UNITY_Q14) begin
            right_v -= left_v - UNITY_Q14;
            left_v   = UNITY_Q14;
          end else if (right_v > UNITY_Q14) begin
            left_v  -= right_v - UNITY_Q14;
            right_v  = UNITY_Q14;
          end
          // then any negative overflow
          if (left_v < -UNITY_Q14) begin
            right_v -= left_v + UNITY_Q14;
            left_v   = -UNITY_Q14;
          end else if (right_v < -UNITY_Q14) begin
            left_v  -= right_v + UNITY_Q14;
            right_v  = -UNITY_Q14;
          end
          mask = present_mask;
        end
        ACT_RIGHT: begin
          right_v = s;
          mask    = present_mask & right_mask;
        end
        ACT_LEFT: begin
          left_v = s;
          mask   = present_mask & ~right_mask;
        end
        default: ;
      endcase
      for (int k = 0; k < ADM_CHANNELS; k++) begin
        v = 0;
        if (mask[k]) begin
          v = right_mask[k] ? right_v : left_v;
          if (reverse_mask[k]) v = -v;
        end
        exp_r.drive[k] = v[15:0];
      end
      exp_r.write_mask = mask;
      expected_drive_q.push_back(exp_r);
    endfunction

    // Compare one strobed result with the oldest prediction
    function void check_result(drive_result_t got);
      drive_result_t exp_r;
      if (expected_drive_q.size() == 0) begin
        $error("out_strobe with no command outstanding");
        failures++;
        return;
      end
      exp_r = expected_drive_q.pop_front();
      for (int k = 0; k < ADM_CHANNELS; k++) begin
        if (got.drive[k] !== exp_r.drive[k]) begin
          $error("drive_%0d: expected %0d, got %0d", k,
                 $signed(exp_r.drive[k]), $signed(got.drive[k]));
          failures++;
        end
      end
      if (got.write_mask !== exp_r.write_mask) begin
        $error("write_mask: expected %02h, got %02h", exp_r.write_mask, got.write_mask);
        failures++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [1:0]           in_action;
  logic signed [15:0]   in_speed;
  logic signed [15:0]   in_turn;
  logic                 cfg_we;
  logic [1:0]           cfg_index;
  logic [ADM_CFG_W-1:0] cfg_wdata;
  logic                 out_strobe;
  logic signed [15:0]   out_drive_0;
  logic signed [15:0]   out_drive_1;
  logic signed [15:0]   out_drive_2;
  logic signed [15:0]   out_drive_3;
  logic signed [15:0]   out_drive_4;
  logic signed [15:0]   out_drive_5;
  logic signed [15:0]   out_drive_6;
  logic signed [15:0]   out_drive_7;
  logic [7:0]           out_write_mask;

  drive_mix_scoreboard sb = new();

  arcade_drive_mixer_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_speed       (in_speed),
    .in_turn        (in_turn),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_strobe     (out_strobe),
    .out_drive_0    (out_drive_0),
    .out_drive_1    (out_drive_1),
    .out_drive_2    (out_drive_2),
    .out_drive_3    (out_drive_3),
    .out_drive_4    (out_drive_4),
    .out_drive_5    (out_drive_5),
    .out_drive_6    (out_drive_6),
    .out_drive_7    (out_drive_7),
    .out_write_mask (out_write_mask)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Take each strobed result at the edge that ends its cycle
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      sb.check_result('{drive: {out_drive_7, out_drive_6, out_drive_5, out_drive_4,
                                out_drive_3, out_drive_2, out_drive_1, out_drive_0},
                        write_mask: out_write_mask});
    end
  end

  // Hold a command until its transfer, then note it
  task automatic send_command(logic [1:0] action, logic signed [15:0] speed,
                              logic signed [15:0] turn);
    start     <= 1'b1;
    in_action <= action;
    in_speed  <= speed;
    in_turn   <= turn;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_command(action, speed, turn);
  endtask

  // Drop start for a random stretch, pct cycles in a hundred
  task automatic idle_sender(int pct);
    if (pct > 0 && $urandom_range(99) < pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < pct);
    end
  endtask

  // Drop start and wait until every outstanding result has come back
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Write all three registers while the pipeline is empty
  task automatic program_registers(chan_mask_t present, chan_mask_t reverse,
                                   chan_mask_t right_side);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= REG_PRESENT;
    cfg_wdata <= present;
    @(posedge clk);
    cfg_index <= REG_REVERSE;
    cfg_wdata <= reverse;
    @(posedge clk);
    cfg_index <= REG_RIGHT_SIDE;
    cfg_wdata <= right_side;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.present_mask = present;
    sb.reverse_mask = reverse;
    sb.right_mask   = right_side;
  endtask

  // Mostly in-range values, with corners and raw 16-bit noise mixed in
  function automatic logic signed [15:0] pick_q14();
    logic signed [15:0] v;
    case ($urandom_range(9))
      0, 1: v = 16'($urandom);
      2: begin
        case ($urandom_range(5))
          0: v = 16'sh8000;
          1: v = 16'sh7FFF;
          2: v = 16'sd16384;
          3: v = -16'sd16384;
          4: v = 16'sd16385;
          default: v = -16'sd16385;
        endcase
      end
      default: v = 16'($urandom_range(32768)) - 16'sd16384;
    endcase
    return v;
  endfunction

  function automatic logic [1:0] pick_action();
    int r;
    r = $urandom_range(19);
    if (r == 0) return ACT_NONE;
    if (r < 12) return ACT_ARCADE;
    if (r < 16) return ACT_RIGHT;
    return ACT_LEFT;
  endfunction

  initial begin
    int pct;
    int guard;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_action <= ACT_ARCADE;
    in_speed  <= '0;
    in_turn   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_PRESENT;
    cfg_wdata <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers: nothing is present, so nothing is written
    send_command(ACT_ARCADE, 16'sd8000, 16'sd100);
    send_command(ACT_RIGHT, -16'sd5000, 16'sd0);

    // directed: clamping, floor halving, desaturation both ways, reversal at -1.0
    program_registers(8'hFF, 8'h5A, RIGHT_SIDE_RESET);
    send_command(ACT_ARCADE, 16'sd0, 16'sd0);
    send_command(ACT_ARCADE, 16'sd16384, 16'sd0);
    send_command(ACT_ARCADE, -16'sd16384, 16'sd0);
    send_command(ACT_ARCADE, 16'sh7FFF, 16'sh7FFF);
    send_command(ACT_ARCADE, 16'sh8000, 16'sh8000);
    send_command(ACT_ARCADE, 16'sd16384, -16'sd16384);
    send_command(ACT_ARCADE, -16'sd16384, 16'sd16384);
    send_command(ACT_ARCADE, -16'sd16384, -16'sd16384);
    send_command(ACT_ARCADE, 16'sd0, -16'sd1);
    send_command(ACT_ARCADE, 16'sd0, 16'sd1);
    send_command(ACT_ARCADE, 16'sd16385, -16'sd16385);
    send_command(ACT_ARCADE, 16'sd0, 16'sh7FFF);
    send_command(ACT_ARCADE, 16'sd1, 16'sh8000);
    send_command(ACT_RIGHT, 16'sh7FFF, 16'sd0);
    send_command(ACT_RIGHT, 16'sh8000, 16'sh7FFF);
    send_command(ACT_RIGHT, -16'sd16384, 16'sd0);
    send_command(ACT_RIGHT, 16'sd100, 16'sd0);
    send_command(ACT_LEFT, 16'sh7FFF, 16'sd0);
    send_command(ACT_LEFT, 16'sh8000, 16'sh8000);
    send_command(ACT_LEFT, -16'sd16384, 16'sd0);
    send_command(ACT_LEFT, -16'sd5, 16'sd0);
    send_command(ACT_NONE, 16'sd1234, -16'sd4321);
    send_command(ACT_NONE, 16'sh7FFF, 16'sh7FFF);

    // random: six register settings, sender idling light, heavy, then not at all
    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        0: program_registers(8'hFF, 8'h00, 8'hF0);
        1: program_registers(8'hFF, 8'hFF, 8'h0F);
        2: program_registers(8'hFF, 8'hA5, 8'hFF);
        3: program_registers(8'hFF, 8'h00, 8'h00);
        default: program_registers(8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      pct = (seg < 2) ? 21 : (seg < 4) ? 88 : 0;
      for (int i = 0; i < 167; i++) begin
        if (seg == 5 && i == 80) drain_results();
        idle_sender(pct);
        send_command(pick_action(), pick_q14(), pick_q14());
      end
    end

    // let the pipeline empty, with a bound
    start <= 1'b0;
    for (guard = 0; sb.pending() != 0 && guard < 1000; guard++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d results never arrived", sb.pending());
      sb.failures++;
    end
    if (sb.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
